/* hw/rtl/ring_finger_table_engine_defines.svh */
// assertion macros for the ring finger table engine
`ifndef RING_FINGER_TABLE_ENGINE_DEFINES_SVH
`define RING_FINGER_TABLE_ENGINE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define RFTE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rfte check failed");

// next-cycle implication, sampled on clk, off during reset
`define RFTE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rfte check failed");

`endif

/* hw/rtl/rfte_pkg.sv */
`default_nettype none

package rfte_pkg;

    localparam int ID_BITS   = 6;
    localparam int MAX_SITES = 16;

    localparam int SITE_W   = $clog2(MAX_SITES);
    localparam int ACT_W    = 5;
    localparam int FINGER_W = 3;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic                cmd;
        logic [SITE_W-1:0]   site_index;
        logic [ID_BITS-1:0]  ring_id;
    } req_word_t;

    typedef struct packed {
        logic [SITE_W-1:0]   node_index;
        logic [FINGER_W-1:0] finger_number;
        logic [ID_BITS-1:0]  finger_id;
        logic                bad_query;
        logic                last;
    } rsp_word_t;

endpackage

`default_nettype wire

/* hw/rtl/ring_finger_table_engine.sv */
// load word: no result, next word accepted the cycle after
// query word with n active sites: the own id is read first, then per finger the n
//   entries of the id table are scanned and the result is held in the output state;
//   the pace is set by the single read port of the id table;
//   a bad query gives its one result in the cycle after acceptance
// reset (async, active low): sequencer idle, no result pending, active_sites = 16
`default_nettype none

module ring_finger_table_engine (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_wr_en,
    input  wire logic [rfte_pkg::ACT_W-1:0] cfg_wr_data,
    input  wire logic                     req_valid,
    output logic                          req_stall,
    input  wire rfte_pkg::req_word_t      req,
    output logic                          rsp_valid,
    input  wire logic                     rsp_stall,
    output rfte_pkg::rsp_word_t           rsp
);

    typedef enum logic [1:0] {ST_IDLE, ST_OWN, ST_SCAN, ST_OUT} state_t;

    localparam int SW = rfte_pkg::SITE_W;
    localparam int IW = rfte_pkg::ID_BITS;
    localparam int FW = rfte_pkg::FINGER_W;
    localparam int AW = rfte_pkg::ACT_W;

    state_t              state_reg, state_next;
    logic [AW-1:0]       active_reg, active_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rfte_pkg::rsp_word_t rsp_reg, rsp_next;
    logic [SW-1:0]       site_reg, site_next;
    logic [IW-1:0]       own_reg, own_next;
    logic [FW-1:0]       finger_reg, finger_next;
    logic [SW-1:0]       k_reg, k_next;
    logic [IW-1:0]       low_reg, low_next;
    logic [IW-1:0]       best_reg, best_next;
    logic                found_reg, found_next;

    logic [AW-1:0] live_n;
    logic [SW-1:0] last_k;
    logic [IW-1:0] target;
    logic [IW-1:0] rd_data;
    logic [SW-1:0] rd_addr;
    logic          wr_en;
    logic          accept;
    logic          first, found_eff, hit;
    logic [IW-1:0] low_c, best_c;
    logic          found_c;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // active count clipped to the table size
    assign live_n = (active_reg > AW'(rfte_pkg::MAX_SITES)) ? AW'(rfte_pkg::MAX_SITES)
                                                           : active_reg;
    assign last_k = SW'(live_n - AW'(1));
    assign target = own_reg + (IW'(1) << finger_reg);
    assign wr_en  = accept && (req.cmd == rfte_pkg::CMD_LOAD);

    rfte_ram #(
        .WIDTH (IW),
        .DEPTH (rfte_pkg::MAX_SITES)
    ) u_id_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (req.site_index),
        .wr_data (req.ring_id),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // shared compare unit: one table entry per cycle in the scan state
    always_comb
    begin
        first     = (k_reg == '0);
        found_eff = !first && found_reg;
        hit       = (rd_data >= target);
        low_c     = (first || rd_data < low_reg) ? rd_data : low_reg;
        best_c    = (hit && (!found_eff || rd_data < best_reg)) ? rd_data : best_reg;
        found_c   = found_eff || hit;
    end

    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        site_next      = site_reg;
        own_next       = own_reg;
        finger_next    = finger_reg;
        k_next         = k_reg;
        low_next       = low_reg;
        best_next      = best_reg;
        found_next     = found_reg;
        rd_addr        = '0;

        if (cfg_wr_en)
        begin
            active_next = cfg_wr_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                rd_addr = req.site_index;
                if (accept && req.cmd == rfte_pkg::CMD_QUERY)
                begin
                    site_next = req.site_index;
                    if (AW'(req.site_index) >= live_n)
                    begin
                        rsp_next.node_index    = req.site_index;
                        rsp_next.finger_number = '0;
                        rsp_next.finger_id     = '0;
                        rsp_next.bad_query     = 1'b1;
                        rsp_next.last          = 1'b1;
                        rsp_valid_next         = 1'b1;
                        state_next             = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_OWN;
                    end
                end
            end
            ST_OWN:
            begin
                // own id is on the read port, entry 0 is being fetched
                own_next    = rd_data;
                finger_next = '0;
                k_next      = '0;
                state_next  = ST_SCAN;
            end
            ST_SCAN:
            begin
                rd_addr    = k_reg + SW'(1);
                low_next   = low_c;
                best_next  = best_c;
                found_next = found_c;
                k_next     = k_reg + SW'(1);
                if (k_reg == last_k)
                begin
                    rsp_next.node_index    = site_reg;
                    rsp_next.finger_number = finger_reg;
                    rsp_next.finger_id     = found_c ? best_c : low_c;
                    rsp_next.bad_query     = 1'b0;
                    rsp_next.last          = (finger_reg == FW'(IW - 1));
                    rsp_valid_next         = 1'b1;
                    state_next             = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // entry 0 stays on the read port for the next finger
                if (!rsp_stall)
                begin
                    rsp_valid_next = 1'b0;
                    if (rsp_reg.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        finger_next = finger_reg + FW'(1);
                        k_next      = '0;
                        state_next  = ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= AW'(rfte_pkg::MAX_SITES);
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        site_reg   <= site_next;
        own_reg    <= own_next;
        finger_reg <= finger_next;
        k_reg      <= k_next;
        low_reg    <= low_next;
        best_reg   <= best_next;
        found_reg  <= found_next;
    end

endmodule

`default_nettype wire

/* hw/rtl/rfte_ram.sv */
`default_nettype none

module rfte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* hw/rtl/rfte_checker.sv */
`default_nettype none
`include "ring_finger_table_engine_defines.svh"

module rfte_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                req_stall,
    input wire logic                rsp_valid,
    input wire logic                rsp_stall,
    input wire rfte_pkg::rsp_word_t rsp
);

    // a stalled result word holds
    `RFTE_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

    // no new word is taken while a result is pending
    `RFTE_ASSERT_NOW(a_busy_out, rsp_valid, req_stall)

    // a bad query is a single closing word with zero payload
    `RFTE_ASSERT_NOW(a_bad_form, rsp_valid && rsp.bad_query,
        rsp.last && rsp.finger_number == '0 && rsp.finger_id == '0)

    // after a non-final result the next finger needs a scan
    `RFTE_ASSERT_NXT(a_gap, rsp_valid && !rsp_stall && !rsp.last, !rsp_valid)

    // after the final result the block is free again
    `RFTE_ASSERT_NXT(a_free, rsp_valid && !rsp_stall && rsp.last, !req_stall)

endmodule

bind ring_finger_table_engine rfte_checker u_rfte_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire
